### sv/bcf_pkg.sv
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types and constants for the cascaded biquad filter: field widths,
// register indexes, the coefficient bundle, the history row layout and the
// control word of the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package bcf_pkg;

  localparam int NUM_STAGES = 4;
  localparam int STG_W      = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int HIST_W     = 24;
  localparam int COEF_FRAC  = 14;
  localparam int PROD_W     = COEF_W + HIST_W;
  // Five exact products need three more bits.
  localparam int ACC_W      = PROD_W + 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (COEF_FRAC - 1));
  localparam logic signed [ACC_W-1:0] HIST_MAX = ACC_W'(2 ** (HIST_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] HIST_MIN = -ACC_W'(2 ** (HIST_W - 1));

  localparam logic signed [HIST_W-1:0] Q15_MAX_H = HIST_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [HIST_W-1:0] Q15_MIN_H = -HIST_W'(2 ** (SAMPLE_W - 1));
  localparam logic signed [SAMPLE_W:0] Q15_MAX_S = (SAMPLE_W + 1)'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [SAMPLE_W:0] Q15_MIN_S = -(SAMPLE_W + 1)'(2 ** (SAMPLE_W - 1));

  // Term counter value at which the last product is added.
  localparam logic [2:0] MAC_LAST = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_B1     = 3'd1,
    REG_B2     = 3'd2,
    REG_A1     = 3'd3,
    REG_A2     = 3'd4,
    REG_ENABLE = 3'd5,
    REG_OFFSET = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    TERM_B0 = 3'd0,
    TERM_B1 = 3'd1,
    TERM_B2 = 3'd2,
    TERM_A1 = 3'd3,
    TERM_A2 = 3'd4
  } term_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]   b0;
    logic signed [COEF_W-1:0]   b1;
    logic signed [COEF_W-1:0]   b2;
    logic signed [COEF_W-1:0]   a1;
    logic signed [COEF_W-1:0]   a2;
    logic                       enable;
    logic signed [SAMPLE_W-1:0] offset;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [HIST_W-1:0] in1;
    logic signed [HIST_W-1:0] in2;
    logic signed [HIST_W-1:0] out1;
    logic signed [HIST_W-1:0] out2;
  } hist_row_t;

  typedef struct packed {
    term_t term;
    logic  prod_en;
    logic  acc_en;
    logic  acc_first;
    logic  acc_sub;
  } mac_ctl_t;

endpackage

### sv/bcf_ram.sv
// ----------------------------------------------------------------------------
// bcf_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bcf_ram #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/bcf_cfg.sv
// ----------------------------------------------------------------------------
// bcf_cfg
// Configuration registers. A coefficient write also raises a one-cycle
// request to clear the filter history.
// ----------------------------------------------------------------------------
module bcf_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcf_pkg::CFG_DATA_W-1:0] cfg_data,
  output bcf_pkg::cfg_regs_t             regs,
  output logic                           hist_clr
);

  bcf_pkg::cfg_regs_t regs_r;
  bcf_pkg::cfg_regs_t regs_nxt;
  logic               wr;

  assign wr = cfg_valid && cfg_ready;

  always_comb begin
    regs_nxt = regs_r;
    hist_clr = 1'b0;
    if (wr) begin
      case (cfg_index)
        bcf_pkg::REG_B0: begin
          regs_nxt.b0 = cfg_data;
        end
        bcf_pkg::REG_B1: begin
          regs_nxt.b1 = cfg_data;
        end
        bcf_pkg::REG_B2: begin
          regs_nxt.b2 = cfg_data;
        end
        bcf_pkg::REG_A1: begin
          regs_nxt.a1 = cfg_data;
        end
        bcf_pkg::REG_A2: begin
          regs_nxt.a2 = cfg_data;
        end
        bcf_pkg::REG_ENABLE: begin
          regs_nxt.enable = cfg_data[0];
        end
        bcf_pkg::REG_OFFSET: begin
          regs_nxt.offset = cfg_data;
        end
        default: begin
        end
      endcase
      hist_clr = cfg_index inside {bcf_pkg::REG_B0, bcf_pkg::REG_B1, bcf_pkg::REG_B2,
                                   bcf_pkg::REG_A1, bcf_pkg::REG_A2};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.b0     <= bcf_pkg::COEF_W'(16384);
      regs_r.b1     <= '0;
      regs_r.b2     <= '0;
      regs_r.a1     <= '0;
      regs_r.a2     <= '0;
      regs_r.enable <= 1'b1;
      regs_r.offset <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

### sv/bcf_mac.sv
// ----------------------------------------------------------------------------
// bcf_mac
// Shared multiply-accumulate unit. One 16 x 24 bit product per cycle goes
// into a product register and is added or subtracted on the next cycle. The
// finished sum is rounded to the sample scale and saturated to 24 bits.
// ----------------------------------------------------------------------------
module bcf_mac (
  input  logic                              clk,
  input  bcf_pkg::mac_ctl_t                 ctl,
  input  bcf_pkg::cfg_regs_t                regs,
  input  logic signed [bcf_pkg::HIST_W-1:0] x,
  input  bcf_pkg::hist_row_t                row,
  output logic signed [bcf_pkg::HIST_W-1:0] y
);

  logic signed [bcf_pkg::COEF_W-1:0] coef_sel;
  logic signed [bcf_pkg::HIST_W-1:0] opnd_sel;
  logic signed [bcf_pkg::PROD_W-1:0] prod_nxt;
  logic signed [bcf_pkg::PROD_W-1:0] prod_r;
  logic signed [bcf_pkg::ACC_W-1:0]  acc_base;
  logic signed [bcf_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [bcf_pkg::ACC_W-1:0]  acc_r;
  logic signed [bcf_pkg::ACC_W-1:0]  rnd;
  logic signed [bcf_pkg::ACC_W-1:0]  shifted;

  always_comb begin
    case (ctl.term)
      bcf_pkg::TERM_B0: begin
        coef_sel = regs.b0;
        opnd_sel = x;
      end
      bcf_pkg::TERM_B1: begin
        coef_sel = regs.b1;
        opnd_sel = row.in1;
      end
      bcf_pkg::TERM_B2: begin
        coef_sel = regs.b2;
        opnd_sel = row.in2;
      end
      bcf_pkg::TERM_A1: begin
        coef_sel = regs.a1;
        opnd_sel = row.out1;
      end
      bcf_pkg::TERM_A2: begin
        coef_sel = regs.a2;
        opnd_sel = row.out2;
      end
      default: begin
        coef_sel = '0;
        opnd_sel = '0;
      end
    endcase
  end

  assign prod_nxt = coef_sel * opnd_sel;

  // The feedback terms are subtracted.
  assign acc_base = ctl.acc_first ? '0 : acc_r;
  assign acc_nxt  = ctl.acc_sub ? acc_base - bcf_pkg::ACC_W'(prod_r)
                                : acc_base + bcf_pkg::ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // Adding half an LSB before the arithmetic shift rounds halves upward.
  assign rnd     = acc_r + bcf_pkg::RND_HALF;
  assign shifted = rnd >>> bcf_pkg::COEF_FRAC;

  always_comb begin
    if (shifted > bcf_pkg::HIST_MAX) begin
      y = bcf_pkg::HIST_MAX[bcf_pkg::HIST_W-1:0];
    end else if (shifted < bcf_pkg::HIST_MIN) begin
      y = bcf_pkg::HIST_MIN[bcf_pkg::HIST_W-1:0];
    end else begin
      y = shifted[bcf_pkg::HIST_W-1:0];
    end
  end

endmodule

### sv/biquad_cascade_filter_unit.sv
// ----------------------------------------------------------------------------
// biquad_cascade_filter_unit
// Cascade of direct-form-I biquad stages sharing one coefficient set, with
// per-stage history kept in a RAM row and one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_sample_in) takes one signed Q15
//   sample per transaction; the output channel (out_valid, out_stall,
//   out_sample_out) returns one saturated Q15 sample for each, in order.
//   The cfg channel writes registers by index while the unit is idle.
//   With the filter enabled, each stage runs its terms through the shared
//   multiply-accumulate unit (five products plus the last add) and then
//   rounds and writes back its history row, while the next stage's row is
//   read. A new sample is taken only once the previous one has passed
//   every stage and reached the output register. In bypass a sample goes
//   straight to the output register.
//   The result sits in an output register, so the next sample is taken while
//   it waits; a stalled receiver holds the result and only blocks the unit
//   once the following result is ready.
//   Reset loads the register defaults and marks every history row as zero;
//   a coefficient write does the same for the history.
// ----------------------------------------------------------------------------
module biquad_cascade_filter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bcf_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bcf_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_WB   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  localparam logic [bcf_pkg::STG_W-1:0] LastStg = bcf_pkg::STG_W'(bcf_pkg::NUM_STAGES - 1);

  state_t                               state_r, state_nxt;
  logic [2:0]                           k_r, k_nxt;
  logic [bcf_pkg::STG_W-1:0]            stg_r, stg_nxt;
  logic signed [bcf_pkg::HIST_W-1:0]    x_r, x_nxt;
  logic [bcf_pkg::NUM_STAGES-1:0]       hv_r, hv_nxt;
  logic                                 vld_r, vld_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [bcf_pkg::SAMPLE_W-1:0]  out_sample_r, out_sample_nxt;

  bcf_pkg::cfg_regs_t                   regs;
  logic                                 hist_clr;
  bcf_pkg::mac_ctl_t                    mac_ctl;
  bcf_pkg::hist_row_t                   row;
  bcf_pkg::hist_row_t                   wrow;
  logic [$bits(bcf_pkg::hist_row_t)-1:0] rd_data;
  logic signed [bcf_pkg::HIST_W-1:0]    y;

  logic                                 in_acc;
  logic                                 slot_free;
  logic                                 ram_we;
  logic                                 ram_re;
  logic [bcf_pkg::STG_W-1:0]            ram_raddr;
  logic signed [bcf_pkg::SAMPLE_W-1:0]  x_q15;
  logic signed [bcf_pkg::SAMPLE_W:0]    sum;
  logic signed [bcf_pkg::SAMPLE_W-1:0]  res;

  bcf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs),
    .hist_clr  (hist_clr)
  );

  bcf_ram #(
    .Width ($bits(bcf_pkg::hist_row_t)),
    .Depth (bcf_pkg::NUM_STAGES)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stg_r),
    .wdata (wrow),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  bcf_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .regs (regs),
    .x    (x_r),
    .row  (row),
    .y    (y)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // A row that has not been written since the last clear reads as zero.
  assign row  = vld_r ? bcf_pkg::hist_row_t'(rd_data) : '0;
  assign wrow = '{in1: x_r, in2: row.in1, out1: y, out2: row.out1};

  assign ram_we = (state_r == ST_WB);

  always_comb begin
    mac_ctl.term      = bcf_pkg::term_t'(k_r);
    mac_ctl.prod_en   = (state_r == ST_MAC) && (k_r != bcf_pkg::MAC_LAST);
    mac_ctl.acc_en    = (state_r == ST_MAC) && (k_r != 3'd0);
    mac_ctl.acc_first = (k_r == 3'd1);
    mac_ctl.acc_sub   = (k_r >= 3'd4);
  end

  // Final saturation to Q15, then the offset with a second saturation.
  always_comb begin
    if (x_r > bcf_pkg::Q15_MAX_H) begin
      x_q15 = bcf_pkg::Q15_MAX_H[bcf_pkg::SAMPLE_W-1:0];
    end else if (x_r < bcf_pkg::Q15_MIN_H) begin
      x_q15 = bcf_pkg::Q15_MIN_H[bcf_pkg::SAMPLE_W-1:0];
    end else begin
      x_q15 = x_r[bcf_pkg::SAMPLE_W-1:0];
    end
    sum = (bcf_pkg::SAMPLE_W + 1)'(x_q15) + (bcf_pkg::SAMPLE_W + 1)'(regs.offset);
    if (sum > bcf_pkg::Q15_MAX_S) begin
      res = bcf_pkg::Q15_MAX_S[bcf_pkg::SAMPLE_W-1:0];
    end else if (sum < bcf_pkg::Q15_MIN_S) begin
      res = bcf_pkg::Q15_MIN_S[bcf_pkg::SAMPLE_W-1:0];
    end else begin
      res = sum[bcf_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    stg_nxt        = stg_r;
    x_nxt          = x_r;
    hv_nxt         = hv_r;
    vld_nxt        = vld_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    ram_re         = 1'b0;
    ram_raddr      = stg_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt = bcf_pkg::HIST_W'(in_sample_in);
          if (regs.enable) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            stg_nxt   = '0;
            k_nxt     = '0;
            state_nxt = ST_MAC;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_MAC: begin
        if (k_r == bcf_pkg::MAC_LAST) begin
          state_nxt = ST_WB;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      ST_WB: begin
        hv_nxt[stg_r] = 1'b1;
        x_nxt         = y;
        if (stg_r == LastStg) begin
          state_nxt = ST_OUT;
        end else begin
          // The next stage's row is read while this one is written back.
          ram_re    = 1'b1;
          ram_raddr = stg_r + 1'b1;
          stg_nxt   = stg_r + 1'b1;
          k_nxt     = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ram_re) begin
      vld_nxt = hv_r[ram_raddr];
    end
    if (hist_clr) begin
      hv_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      stg_r       <= '0;
      hv_r        <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      stg_r       <= stg_nxt;
      hv_r        <= hv_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    out_sample_r <= out_sample_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  a_wb_only: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_WB))
    else $error("history written outside write-back");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re && (ram_raddr == stg_r)))
    else $error("history row read and written in the same cycle");

  a_clr_hist: assert property (@(posedge clk) disable iff (!rst_n)
    hist_clr |=> (hv_r == '0))
    else $error("history valid bits not cleared after coefficient write");

  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (k_r <= bcf_pkg::MAC_LAST))
    else $error("term counter out of range");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for biquad_cascade_filter_unit. A queue-fed driver sends
// Q15 samples, a monitor compares every returned sample with a bit-true
// prediction of the four-stage cascade, and register settings change between
// phases while the unit is idle. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_SAMPLES  = 105;

  // Index 7 has no register behind it; writes to it must change nothing.
  localparam logic [bcf_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam longint SMP_HI  = (longint'(1) << (bcf_pkg::SAMPLE_W - 1)) - 1;
  localparam longint SMP_LO  = -(longint'(1) << (bcf_pkg::SAMPLE_W - 1));
  localparam longint HIST_HI = (longint'(1) << (bcf_pkg::HIST_W - 1)) - 1;
  localparam longint HIST_LO = -(longint'(1) << (bcf_pkg::HIST_W - 1));

  typedef struct {
    logic [bcf_pkg::CFG_IDX_W-1:0]  idx;
    logic [bcf_pkg::CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [bcf_pkg::SAMPLE_W-1:0] in_sample_in = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [bcf_pkg::SAMPLE_W-1:0] out_sample_out;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [bcf_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [bcf_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  biquad_cascade_filter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers and the per-stage history.
  logic signed [bcf_pkg::COEF_W-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic                                enable_q;
  logic signed [bcf_pkg::SAMPLE_W-1:0] offset_q;
  logic signed [bcf_pkg::HIST_W-1:0]   hin1 [bcf_pkg::NUM_STAGES];
  logic signed [bcf_pkg::HIST_W-1:0]   hin2 [bcf_pkg::NUM_STAGES];
  logic signed [bcf_pkg::HIST_W-1:0]   hout1 [bcf_pkg::NUM_STAGES];
  logic signed [bcf_pkg::HIST_W-1:0]   hout2 [bcf_pkg::NUM_STAGES];

  logic signed [bcf_pkg::SAMPLE_W-1:0] samples_to_send [$];
  logic signed [bcf_pkg::SAMPLE_W-1:0] predicted_out [$];
  reg_write_t                          reg_writes [$];

  int error_cnt = 0;
  int samples_taken = 0;
  int bypass_taken = 0;
  int samples_checked = 0;
  int writes_done = 0;
  int settings_run = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;

  int   tx_gap_left = 0;
  int   rx_gap_left = 0;
  int   hold_cnt = 0;
  logic hold_req = 1'b0;
  logic hold_active = 1'b0;
  logic hold_done = 1'b0;
  logic stall_next;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_history();
    for (int s = 0; s < bcf_pkg::NUM_STAGES; s++) begin
      hin1[s] = '0;
      hin2[s] = '0;
      hout1[s] = '0;
      hout2[s] = '0;
    end
  endfunction

  function automatic void reset_filter_model();
    b0_q = 16'sd16384;
    b1_q = '0;
    b2_q = '0;
    a1_q = '0;
    a2_q = '0;
    enable_q = 1'b1;
    offset_q = '0;
    clear_history();
  endfunction

  function automatic void apply_reg(logic [bcf_pkg::CFG_IDX_W-1:0] idx,
                                    logic [bcf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      bcf_pkg::REG_B0: begin b0_q = data; clear_history(); end
      bcf_pkg::REG_B1: begin b1_q = data; clear_history(); end
      bcf_pkg::REG_B2: begin b2_q = data; clear_history(); end
      bcf_pkg::REG_A1: begin a1_q = data; clear_history(); end
      bcf_pkg::REG_A2: begin a2_q = data; clear_history(); end
      bcf_pkg::REG_ENABLE: enable_q = data[0];
      bcf_pkg::REG_OFFSET: offset_q = data;
      default: ;
    endcase
  endfunction

  // Runs one sample through the cascade and updates the history.
  function automatic logic signed [bcf_pkg::SAMPLE_W-1:0] filter_sample(
      logic signed [bcf_pkg::SAMPLE_W-1:0] smp);
    longint x;
    longint acc;
    x = smp;
    if (enable_q) begin
      for (int s = 0; s < bcf_pkg::NUM_STAGES; s++) begin
        acc = b0_q * x + b1_q * hin1[s] + b2_q * hin2[s]
            - a1_q * hout1[s] - a2_q * hout2[s];
        acc = clamp((acc + (longint'(1) << (bcf_pkg::COEF_FRAC - 1))) >>> bcf_pkg::COEF_FRAC,
                    HIST_LO, HIST_HI);
        hin2[s] = hin1[s];
        hin1[s] = bcf_pkg::HIST_W'(x);
        hout2[s] = hout1[s];
        hout1[s] = bcf_pkg::HIST_W'(acc);
        x = acc;
      end
      x = clamp(x, SMP_LO, SMP_HI);
    end
    return bcf_pkg::SAMPLE_W'(clamp(x + offset_q, SMP_LO, SMP_HI));
  endfunction

  function automatic logic signed [bcf_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return bcf_pkg::SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return bcf_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // Driver: presents the next queued sample once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        if (!enable_q) bypass_taken++;
        predicted_out.push_back(filter_sample(in_sample_in));
        samples_taken++;
      end
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          tx_gap_left = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          in_sample_in <= samples_to_send.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each returned sample and decides the receiver's stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_out.size() == 0) begin
          $error("sample_out with no transaction pending: got %0d", out_sample_out);
          error_cnt++;
        end else begin
          if (out_sample_out !== predicted_out[0]) begin
            $error("sample_out mismatch: expected %0d, got %0d",
                   predicted_out[0], out_sample_out);
            error_cnt++;
          end
          void'(predicted_out.pop_front());
          samples_checked++;
        end
      end
      if (hold_req && !hold_done && !hold_active) begin
        hold_active = 1'b1;
        hold_cnt = 0;
      end
      if (hold_active) begin
        stall_next = (hold_cnt < LONG_HOLD);
        hold_cnt++;
        if (!stall_next) begin
          hold_active = 1'b0;
          hold_done = 1'b1;
        end
      end else if (rx_gap_left > 0) begin
        stall_next = 1'b1;
        rx_gap_left--;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_next = 1'b1;
        rx_gap_left = $urandom_range(0, 9);
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_reg(logic [bcf_pkg::CFG_IDX_W-1:0] idx, int data);
    reg_write_t w;
    w.idx = idx;
    w.data = bcf_pkg::CFG_DATA_W'(data);
    reg_writes.push_back(w);
  endtask

  // Waits until every queued sample has been sent and answered.
  task automatic wait_idle();
    while (samples_to_send.size() != 0 || in_valid || predicted_out.size() != 0)
      @(posedge clk);
  endtask

  task automatic program_regs();
    wait_idle();
    while (reg_writes.size() > 0) begin
      cfg_index <= reg_writes[0].idx;
      cfg_data <= reg_writes[0].data;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(reg_writes[0].idx, reg_writes[0].data);
      void'(reg_writes.pop_front());
      writes_done++;
    end
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // Mostly stable sections, sometimes wild coefficients, bypass or an
  // offset-only change that must keep the history.
  task automatic plan_setting();
    int a2v;
    int a1span;
    case ($urandom_range(0, 9))
      0: begin
        queue_reg(bcf_pkg::REG_ENABLE, $urandom & 16'hfffe);
        queue_reg(bcf_pkg::REG_OFFSET, $urandom);
      end
      1: begin
        queue_reg(bcf_pkg::REG_B0, $urandom);
        queue_reg(bcf_pkg::REG_B1, $urandom);
        queue_reg(bcf_pkg::REG_B2, $urandom);
        queue_reg(bcf_pkg::REG_A1, $urandom);
        queue_reg(bcf_pkg::REG_A2, $urandom);
        queue_reg(bcf_pkg::REG_ENABLE, 1);
        queue_reg(bcf_pkg::REG_OFFSET, $urandom);
      end
      2: begin
        queue_reg(bcf_pkg::REG_ENABLE, $urandom | 1);
        queue_reg(bcf_pkg::REG_OFFSET, int'($urandom_range(0, 2000)) - 1000);
      end
      default: begin
        a2v = $urandom_range(0, 14745);
        a1span = 16384 + a2v - 1;
        queue_reg(bcf_pkg::REG_B0, int'($urandom_range(0, 16384)) - 8192);
        queue_reg(bcf_pkg::REG_B1, int'($urandom_range(0, 16384)) - 8192);
        queue_reg(bcf_pkg::REG_B2, int'($urandom_range(0, 8192)) - 4096);
        queue_reg(bcf_pkg::REG_A1, int'($urandom_range(0, 2 * a1span)) - a1span);
        queue_reg(bcf_pkg::REG_A2, a2v);
        queue_reg(bcf_pkg::REG_ENABLE, 1);
        queue_reg(bcf_pkg::REG_OFFSET, $urandom_range(0, 3) == 0 ? $urandom : 0);
      end
    endcase
  endtask

  initial begin
    reset_filter_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings are unity gain, so samples pass straight through.
    idle_pct = 20;
    samples_to_send = {16'sd0, 16'sh7fff, 16'sh8000, 16'sd1, -16'sd1,
                       16'sh5555, 16'shaaaa};

    // Half gain per stage with odd inputs lands exactly on rounding halves.
    queue_reg(bcf_pkg::REG_B0, 8192);
    program_regs();
    samples_to_send = {16'sd1, -16'sd1, 16'sd3, -16'sd3};

    // Bypass with both offset extremes; stray upper bits in the enable word
    // and a write to the spare index must be ignored.
    queue_reg(bcf_pkg::REG_ENABLE, 16'hfffe);
    queue_reg(bcf_pkg::REG_OFFSET, 32767);
    queue_reg(REG_SPARE, 16'hffff);
    program_regs();
    samples_to_send = {16'sh7fff, 16'sh8000, 16'sd0};
    queue_reg(bcf_pkg::REG_OFFSET, -32768);
    program_regs();
    samples_to_send = {16'sh8000, 16'sd100};

    // Extreme coefficients drive the history into saturation.
    queue_reg(bcf_pkg::REG_B0, -32768);
    queue_reg(bcf_pkg::REG_B1, 32767);
    queue_reg(bcf_pkg::REG_B2, -32768);
    queue_reg(bcf_pkg::REG_A1, -32768);
    queue_reg(bcf_pkg::REG_A2, 32767);
    queue_reg(bcf_pkg::REG_ENABLE, 16'h8001);
    queue_reg(bcf_pkg::REG_OFFSET, 0);
    program_regs();
    samples_to_send = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, -16'sd1, 16'sd1};

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      plan_setting();
      program_regs();
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      if (p == RANDOM_PHASES - 1) idle_pct = 0;
      // One long receiver hold while the sender keeps offering samples.
      if (p == 2) hold_req <= 1'b1;
      for (int k = 0; k < PHASE_SAMPLES; k++)
        samples_to_send.push_back(rand_sample());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d samples (%0d bypassed) over %0d register settings, %0d writes.",
             samples_taken, bypass_taken, settings_run, writes_done);
    $display("Checked %0d results; the receiver held off once for %0d cycles.",
             samples_checked, LONG_HOLD);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
sv/bcf_pkg.sv
sv/bcf_ram.sv
sv/bcf_cfg.sv
sv/bcf_mac.sv
sv/biquad_cascade_filter_unit.sv
sim/testbench.sv
